[src/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Types and constants shared by the ray against box slab test unit.
// ----------------------------------------------------------------------------
package rbst_pkg;

    // Number format: signed fixed point, COORD_W bits with FRAC_W fraction bits.
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;

    // Magnitude widths of the slab division.
    localparam int NUM_W = COORD_W + FRAC_W;
    localparam int DEN_W = COORD_W;

    // Register stages in one divider lane: two set-up stages, one per quotient
    // bit, and one saturation stage.
    localparam int LANE_LAT = NUM_W + 3;

    localparam logic signed [COORD_W-1:0] VAL_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] VAL_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_T_START  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_T_END    = 3'd7;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } t_box;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] t_enter;
        logic signed [COORD_W-1:0] t_exit;
    } t_result;

    // Per-item control that travels beside the divider lanes.
    typedef struct packed {
        logic valid;
        logic miss;
    } t_ctl;

endpackage

[src/rbst_div_lane.sv]
// ----------------------------------------------------------------------------
// rbst_div_lane
// One slab time lane: (bound - origin) * 2^FRAC_W / dir, truncated toward
// zero and saturated, through a fully pipelined restoring divider.
// ----------------------------------------------------------------------------
module rbst_div_lane
    import rbst_pkg::*;
(
    input  logic   i_clk,
    input  t_coord i_bound,
    input  t_coord i_origin,
    input  t_coord i_dir,
    output t_coord o_slab
);

    // Set-up stage one: exact difference and direction.
    logic signed [COORD_W:0] r_diff;
    t_coord                  r_dir;

    always_ff @(posedge i_clk) begin
        r_diff <= {i_bound[COORD_W-1], i_bound} - {i_origin[COORD_W-1], i_origin};
        r_dir  <= i_dir;
    end

    // Set-up stage two: magnitudes and quotient sign.
    logic signed [COORD_W:0] n_diff_abs;
    logic signed [COORD_W:0] n_dir_abs;
    logic [DEN_W:0]          n_dir_ext;

    always_comb begin
        n_diff_abs = r_diff[COORD_W] ? -r_diff : r_diff;
        n_dir_ext  = {r_dir[COORD_W-1], r_dir};
        n_dir_abs  = r_dir[COORD_W-1] ? -$signed(n_dir_ext) : $signed(n_dir_ext);
    end

    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [NUM_W-1:0] r_acc [0:NUM_W];
    logic [DEN_W-1:0] r_den [0:NUM_W];
    logic             r_neg [0:NUM_W];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_acc[0] <= {n_diff_abs[COORD_W-1:0], {FRAC_W{1'b0}}};
        r_den[0] <= n_dir_abs[DEN_W-1:0];
        r_neg[0] <= r_diff[COORD_W] ^ r_dir[COORD_W-1];
    end

    // One quotient bit per stage.
    genvar s;
    generate
        for (s = 0; s < NUM_W; s++) begin : g_stage
            logic [DEN_W:0] n_trial;
            logic           n_bit;

            always_comb begin
                n_trial = {r_rem[s], r_acc[s][NUM_W-1]} - {1'b0, r_den[s]};
                n_bit   = ~n_trial[DEN_W];
            end

            always_ff @(posedge i_clk) begin
                if (n_bit) begin
                    r_rem[s+1] <= n_trial[DEN_W-1:0];
                end else begin
                    r_rem[s+1] <= {r_rem[s][DEN_W-2:0], r_acc[s][NUM_W-1]};
                end
                r_acc[s+1] <= {r_acc[s][NUM_W-2:0], n_bit};
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    endgenerate

    // Saturate the signed quotient to the coordinate range.
    logic [NUM_W-1:0] n_mag;
    logic             n_big;
    logic             n_over;
    t_coord           n_slab;
    t_coord           r_slab;

    always_comb begin
        n_mag  = r_acc[NUM_W];
        n_big  = |n_mag[NUM_W-1:COORD_W-1];
        n_over = |n_mag[NUM_W-1:COORD_W] |
                 (n_mag[COORD_W-1] & (|n_mag[COORD_W-2:0]));
        if (r_neg[NUM_W]) begin
            n_slab = n_over ? VAL_MIN : -$signed(n_mag[COORD_W-1:0]);
        end else begin
            n_slab = n_big ? VAL_MAX : $signed(n_mag[COORD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_slab <= n_slab;
    end

    assign o_slab = r_slab;

endmodule

[src/rbst_merge.sv]
// ----------------------------------------------------------------------------
// rbst_merge
// Orders each axis' slab times, takes the largest entry and smallest exit,
// then tests against the ray interval and narrows it.
// ----------------------------------------------------------------------------
module rbst_merge
    import rbst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl       i_ctl,
    input  t_coord     i_slab [0:5],
    input  logic [2:0] i_dzero,
    input  t_coord     i_t0,
    input  t_coord     i_t1,
    output logic       o_done,
    output t_result    o_result
);

    // Stage A: per-axis entry and exit.
    t_ctl   r_ctl_a;
    t_coord r_ent_a [0:2];
    t_coord r_lev_a [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else begin
            r_ctl_a <= i_ctl;
        end
    end

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            always_ff @(posedge i_clk) begin
                if (i_dzero[a]) begin
                    r_ent_a[a] <= VAL_MIN;
                    r_lev_a[a] <= VAL_MAX;
                end else if (i_slab[a] < i_slab[a+3]) begin
                    r_ent_a[a] <= i_slab[a];
                    r_lev_a[a] <= i_slab[a+3];
                end else begin
                    r_ent_a[a] <= i_slab[a+3];
                    r_lev_a[a] <= i_slab[a];
                end
            end
        end
    endgenerate

    // Stage B: largest entry and smallest exit over the three axes.
    t_ctl   r_ctl_b;
    t_coord r_ent_b;
    t_coord r_lev_b;
    t_coord n_ent_xy;
    t_coord n_lev_xy;

    always_comb begin
        n_ent_xy = (r_ent_a[0] > r_ent_a[1]) ? r_ent_a[0] : r_ent_a[1];
        n_lev_xy = (r_lev_a[0] < r_lev_a[1]) ? r_lev_a[0] : r_lev_a[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_b <= '0;
        end else begin
            r_ctl_b <= r_ctl_a;
        end
        r_ent_b <= (n_ent_xy > r_ent_a[2]) ? n_ent_xy : r_ent_a[2];
        r_lev_b <= (n_lev_xy < r_lev_a[2]) ? n_lev_xy : r_lev_a[2];
    end

    // Stage C: hit test against the interval and narrowing.
    logic    n_hit;
    t_result n_res;
    logic    r_done;
    t_result r_res;

    always_comb begin
        n_hit = ~r_ctl_b.miss && (r_ent_b <= r_lev_b) && (r_ent_b <= i_t1) &&
                (r_lev_b >= i_t0);
        n_res.hit = n_hit;
        if (n_hit) begin
            n_res.t_enter = (r_ent_b > i_t0) ? r_ent_b : i_t0;
            n_res.t_exit  = (r_lev_b < i_t1) ? r_lev_b : i_t1;
        end else begin
            n_res.t_enter = i_t0;
            n_res.t_exit  = i_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_ctl_b.valid;
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[src/ray_box_slab_test_unit.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Slab test of one configured ray against a stream of axis-aligned boxes.
//
//   Channel   Ports                                  Transfer
//   box in    i_start, o_busy, i_box                 i_start high, o_busy low
//   result    o_done, o_result                       o_done high, one cycle
//   config    i_cfg_we, i_cfg_idx, i_cfg_data        i_cfg_we high
//
// One box is taken every cycle; o_busy is always low.
// Each box passes through the six pipelined Q16.16 dividers, one quotient
// bit per stage, and then through merge stages A, B and C to its result.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so nothing ever holds the pipeline.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit
    import rbst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_box                 i_box,
    output logic                 o_done,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    // Configuration registers.
    t_coord r_origin [0:2];
    t_coord r_dir    [0:2];
    t_coord r_t0;
    t_coord r_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
            r_dir[0]    <= t_coord'(1) <<< FRAC_W;
            r_dir[1]    <= '0;
            r_dir[2]    <= '0;
            r_t0        <= '0;
            r_t1        <= VAL_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_origin[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_origin[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_origin[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0]    <= i_cfg_data;
                REG_DIR_Y:    r_dir[1]    <= i_cfg_data;
                REG_DIR_Z:    r_dir[2]    <= i_cfg_data;
                REG_T_START:  r_t0        <= i_cfg_data;
                REG_T_END:    r_t1        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Zero-direction axes with the origin outside the slab miss outright.
    t_coord     n_lo [0:2];
    t_coord     n_hi [0:2];
    logic [2:0] n_dzero;
    logic       n_miss;

    always_comb begin
        n_lo[0] = i_box.box_min_x;
        n_lo[1] = i_box.box_min_y;
        n_lo[2] = i_box.box_min_z;
        n_hi[0] = i_box.box_max_x;
        n_hi[1] = i_box.box_max_y;
        n_hi[2] = i_box.box_max_z;
        n_miss  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_dzero[k] = (r_dir[k] == '0);
            if (n_dzero[k] && ((r_origin[k] < n_lo[k]) || (r_origin[k] > n_hi[k]))) begin
                n_miss = 1'b1;
            end
        end
    end

    // Control shift line kept in step with the divider lanes.
    t_ctl r_ctl [0:LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_ctl[k] <= '0;
            end
        end else begin
            r_ctl[0].valid <= i_start;
            r_ctl[0].miss  <= n_miss;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // Six divider lanes: lower bounds x, y, z then upper bounds x, y, z.
    t_coord w_slab [0:5];

    genvar g;
    generate
        for (g = 0; g < 6; g++) begin : g_lane
            rbst_div_lane u_lane (
                .i_clk    (i_clk),
                .i_bound  (g < 3 ? n_lo[g % 3] : n_hi[g % 3]),
                .i_origin (r_origin[g % 3]),
                .i_dir    (r_dir[g % 3]),
                .o_slab   (w_slab[g])
            );
        end
    endgenerate

    rbst_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_ctl[LANE_LAT-1]),
        .i_slab   (w_slab),
        .i_dzero  (n_dzero),
        .i_t0     (r_t0),
        .i_t1     (r_t1),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

[dv/ray_box_slab_test_unit_tb.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit_tb
// Self-checking bench for the ray against box slab test unit. Rays are set
// through the register port between phases, boxes are driven in random
// bursts, and every result is compared against a slab-test predictor.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit_tb;
    import rbst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = LANE_LAT + 20;

    // One pending box transfer or register write.
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        t_coord               data;
        t_box                 box;
    } t_job;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    t_box                 box;
    logic                 done;
    t_result              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COORD_W-1:0]   cfg_data;

    t_job    job_q[$];
    t_result expected_q[$];
    t_coord  ray_reg[8];
    int      fail_count;
    int      burst_left;
    int      gap_left;
    bit      stim_done;
    bit      hold_drain;

    ray_box_slab_test_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_box      (box),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Saturating fixed-point quotient, truncated toward zero.
    function automatic longint slab_quotient(longint num, longint den);
        longint q;
        q = (num * (longint'(1) << FRAC_W)) / den;
        if (q > longint'(VAL_MAX)) return longint'(VAL_MAX);
        if (q < longint'(VAL_MIN)) return longint'(VAL_MIN);
        return q;
    endfunction

    // Expected result of one box against the current ray.
    function automatic t_result predict_hit(t_box b);
        t_result r;
        longint  lo[3], hi[3];
        longint  o, d, ta, tb, entry, leave, t0, t1;
        bit      ok;
        lo[0] = b.box_min_x; lo[1] = b.box_min_y; lo[2] = b.box_min_z;
        hi[0] = b.box_max_x; hi[1] = b.box_max_y; hi[2] = b.box_max_z;
        t0 = ray_reg[REG_T_START];
        t1 = ray_reg[REG_T_END];
        entry = VAL_MIN;
        leave = VAL_MAX;
        ok = 1'b1;
        for (int ax = 0; ax < 3; ax++) begin
            o = ray_reg[ax];
            d = ray_reg[3 + ax];
            if (d == 0) begin
                // A ray parallel to the slab only survives if it starts inside.
                if (o < lo[ax] || o > hi[ax]) ok = 1'b0;
            end else begin
                ta = slab_quotient(lo[ax] - o, d);
                tb = slab_quotient(hi[ax] - o, d);
                if ((ta < tb ? ta : tb) > entry) entry = ta < tb ? ta : tb;
                if ((ta < tb ? tb : ta) < leave) leave = ta < tb ? tb : ta;
            end
        end
        if (ok && entry <= leave && entry <= t1 && leave >= t0) begin
            r.hit     = 1'b1;
            r.t_enter = t_coord'(entry > t0 ? entry : t0);
            r.t_exit  = t_coord'(leave < t1 ? leave : t1);
        end else begin
            r.hit     = 1'b0;
            r.t_enter = t_coord'(t0);
            r.t_exit  = t_coord'(t1);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return t_coord'($urandom);
            default: return t_coord'($signed($urandom_range(0, 40 << FRAC_W))
                                     - (20 << FRAC_W));
        endcase
    endfunction

    function automatic t_coord rand_dir();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return t_coord'($urandom);
            2: return VAL_MIN;
            default: return t_coord'($signed($urandom_range(1, 4 << FRAC_W))
                                     * ($urandom_range(0, 1) ? 1 : -1));
        endcase
    endfunction

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, t_coord v);
        t_job j;
        j = '{is_cfg: 1'b1, idx: idx, data: v, box: '0};
        job_q.push_back(j);
    endtask

    task automatic add_box(t_box b);
        t_job j;
        j = '{is_cfg: 1'b0, idx: '0, data: '0, box: b};
        job_q.push_back(j);
    endtask

    // Mostly well-formed boxes around the origin, some inverted or random.
    function automatic t_box rand_box();
        t_box   b;
        t_coord a, c;
        if ($urandom_range(0, 9) == 0) return t_box'({$urandom, $urandom, $urandom,
                                                      $urandom, $urandom, $urandom});
        a = rand_coord(); c = rand_coord();
        b.box_min_x = a < c ? a : c; b.box_max_x = a < c ? c : a;
        a = rand_coord(); c = rand_coord();
        b.box_min_y = a < c ? a : c; b.box_max_y = a < c ? c : a;
        a = rand_coord(); c = rand_coord();
        b.box_min_z = a < c ? a : c; b.box_max_z = a < c ? c : a;
        if ($urandom_range(0, 15) == 0) b.box_min_y = b.box_max_y + 1;
        return b;
    endfunction

    // Stimulus: directed boxes against the reset ray and two configured rays, then random rays.
    initial begin
        t_box b;
        b = '{0, 0, 0, 10 << FRAC_W, 0, 0};
        add_box(b);
        b = '{-(5 << FRAC_W), -1, -1, 5 << FRAC_W, 1, 1};
        add_box(b);
        // Origin just outside a zero-direction slab.
        b = '{0, 1, 0, 4 << FRAC_W, 2, 0};
        add_box(b);
        b = '{VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX};
        add_box(b);
        b = '{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN};
        add_box(b);
        // Inverted bound on the moving axis acts swapped.
        b = '{8 << FRAC_W, 0, 0, 2 << FRAC_W, 0, 0};
        add_box(b);
        // Box behind the ray.
        b = '{-(9 << FRAC_W), 0, 0, -(3 << FRAC_W), 0, 0};
        add_box(b);
        b = '{VAL_MIN, 0, 0, VAL_MIN, 0, 0};
        add_box(b);
        // Tiny direction and large distance saturate the quotient.
        add_cfg(REG_DIR_X, 1);
        add_cfg(REG_DIR_Y, VAL_MIN);
        add_cfg(REG_DIR_Z, VAL_MAX);
        add_cfg(REG_ORIGIN_X, VAL_MIN);
        add_cfg(REG_ORIGIN_Y, VAL_MAX);
        add_cfg(REG_ORIGIN_Z, -1);
        add_cfg(REG_T_START, VAL_MIN);
        add_cfg(REG_T_END, VAL_MAX);
        b = '{VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX};
        add_box(b);
        b = '{0, 0, -2, 1, 0, 2};
        add_box(b);
        // Inverted interval.
        add_cfg(REG_T_START, 5 << FRAC_W);
        add_cfg(REG_T_END, -(5 << FRAC_W));
        add_cfg(REG_DIR_Y, -(1 << FRAC_W));
        add_cfg(REG_ORIGIN_X, 0);
        add_cfg(REG_ORIGIN_Y, 0);
        add_cfg(REG_ORIGIN_Z, 0);
        add_cfg(REG_DIR_X, 1 << FRAC_W);
        add_cfg(REG_DIR_Z, 1 << FRAC_W);
        b = '{-(1 << FRAC_W), -(1 << FRAC_W), -(1 << FRAC_W),
              1 << FRAC_W, 1 << FRAC_W, 1 << FRAC_W};
        add_box(b);
        b = '{7 << FRAC_W, -(20 << FRAC_W), 0, 9 << FRAC_W, 20 << FRAC_W, VAL_MAX};
        add_box(b);

        // Random rays, each followed by a batch of boxes.
        for (int ray = 0; ray < 40; ray++) begin
            add_cfg(REG_ORIGIN_X, rand_coord());
            add_cfg(REG_ORIGIN_Y, rand_coord());
            add_cfg(REG_ORIGIN_Z, rand_coord());
            add_cfg(REG_DIR_X, rand_dir());
            add_cfg(REG_DIR_Y, rand_dir());
            add_cfg(REG_DIR_Z, rand_dir());
            add_cfg(REG_T_START, $urandom_range(0, 3) == 0 ? rand_coord() : '0);
            add_cfg(REG_T_END, $urandom_range(0, 3) == 0 ? rand_coord() : VAL_MAX);
            for (int n = 0; n < 25; n++) add_box(rand_box());
        end
    end

    // Reset, held low at start-up and then released.
    initial begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: boxes in random bursts; register writes only once every result
    // in flight has come back. It also pauses for a full drain partway through.
    always @(posedge clk) begin
        logic                 drv_start;
        logic                 drv_we;
        logic [CFG_IDX_W-1:0] drv_idx;
        logic [COORD_W-1:0]   drv_data;
        t_box                 drv_box;
        drv_start = 1'b0;
        drv_we    = 1'b0;
        drv_idx   = '0;
        drv_data  = '0;
        drv_box   = '0;
        if (!rst_n) begin
            ray_reg = '{0, 0, 0, 1 << FRAC_W, 0, 0, 0, VAL_MAX};
        end else begin
            drv_idx  = cfg_idx;
            drv_data = cfg_data;
            drv_box  = box;
            if (start && busy) begin
                // The offered box was not taken; keep it on the ports.
                drv_start = 1'b1;
            end else if (job_q.size() == 0) begin
                stim_done = 1'b1;
            end else if (hold_drain) begin
                if (expected_q.size() == 0) hold_drain = 1'b0;
            end else if (job_q[0].is_cfg) begin
                if (expected_q.size() == 0) begin
                    drv_we   = 1'b1;
                    drv_idx  = job_q[0].idx;
                    drv_data = job_q[0].data;
                    ray_reg[job_q[0].idx] = job_q[0].data;
                    void'(job_q.pop_front());
                end
            end else if (gap_left > 0) begin
                gap_left--;
            end else begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
                end
                drv_start = 1'b1;
                drv_box   = job_q[0].box;
                expected_q.push_back(predict_hit(job_q[0].box));
                void'(job_q.pop_front());
                burst_left--;
                if (job_q.size() == 500) hold_drain = 1'b1;
            end
        end
        start    <= drv_start;
        box      <= drv_box;
        cfg_we   <= drv_we;
        cfg_idx  <= drv_idx;
        cfg_data <= drv_data;
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge clk) begin
        t_result exp_r;
        if (rst_n && done) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_r = expected_q.pop_front();
                if (result.hit !== exp_r.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b",
                                              result.hit, exp_r.hit));
                if (result.t_enter !== exp_r.t_enter)
                    report_mismatch($sformatf("t_enter %0d, expected %0d",
                                              result.t_enter, exp_r.t_enter));
                if (result.t_exit !== exp_r.t_exit)
                    report_mismatch($sformatf("t_exit %0d, expected %0d",
                                              result.t_exit, exp_r.t_exit));
            end
        end
    end

    // End of run once everything has drained.
    initial begin
        wait (stim_done);
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/rbst_pkg.sv
src/rbst_div_lane.sv
src/rbst_merge.sv
src/ray_box_slab_test_unit.sv
dv/ray_box_slab_test_unit_tb.sv
